>>> design/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types, constants and helpers for the masked byte pattern scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int OFFSET_BITS = 32;
    localparam int REG_BYTES   = 32;
    localparam int LEN_LIMIT   = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;
    localparam int LEN_BITS    = $clog2(LEN_LIMIT + 1);
    localparam int IDX_BITS    = $clog2(LEN_LIMIT);
    localparam int ADDR_W      = 64;
    localparam int DATA_W      = 64;
    localparam int PADDR_W     = 6;
    localparam int PAT_WORDS   = 4;
    localparam int LEN_REG_W   = 6;
    localparam int MASK_W      = 32;

    typedef enum logic [2:0] {
        REG_PAT_LOW      = 3'd0,
        REG_PAT_MID_LOW  = 3'd1,
        REG_PAT_MID_HIGH = 3'd2,
        REG_PAT_HIGH     = 3'd3,
        REG_MASK         = 3'd4,
        REG_LENGTH       = 3'd5,
        REG_BASE         = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } t_out_item;

    typedef struct packed {
        logic [PAT_WORDS-1:0][DATA_W-1:0] pattern_words;
        logic [MASK_W-1:0]                compare_mask;
        logic [LEN_REG_W-1:0]             pattern_length;
        logic [ADDR_W-1:0]                base_address;
    } t_cfg;

    // Window byte held by one cell and whether it has been filled yet.
    typedef struct packed {
        logic       full;
        logic [7:0] data;
    } t_cell_state;

    // Pattern byte lined up with one cell.
    typedef struct packed {
        logic       active;
        logic       compare;
        logic [7:0] pattern;
    } t_cell_ref;

    // Length zero counts as one; anything above the limit saturates.
    function automatic logic [LEN_BITS-1:0] eff_len(input logic [LEN_REG_W-1:0] len);
        logic [LEN_REG_W-1:0] v;
        v = len;
        if (v == '0) begin
            v = LEN_REG_W'(1);
        end
        if (v > LEN_REG_W'(LEN_LIMIT)) begin
            v = LEN_REG_W'(LEN_LIMIT);
        end
        return v[LEN_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

>>> design/mbps_cell.sv
// ----------------------------------------------------------------------------
// mbps_cell
// One window position: holds a byte, shifts it on, and checks the byte it is
// about to take against its aligned pattern byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_cell (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_shift,
    input  wire logic                 i_clear,
    input  wire mbps_pkg::t_cell_state i_prev,
    input  wire mbps_pkg::t_cell_ref  i_ref,
    output mbps_pkg::t_cell_state     o_state,
    output logic                      o_ok
);
    import mbps_pkg::*;

    t_cell_state r_state;
    t_cell_state n_state;

    always_comb begin
        n_state = r_state;
        if (i_clear) begin
            n_state = '0;
        end else if (i_shift) begin
            n_state = i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    // The compare looks at the byte that lands here on this shift, so a hit is
    // known in the same cycle the byte is taken.
    assign o_ok = !i_ref.active ||
                  (i_prev.full && (!i_ref.compare || (i_prev.data == i_ref.pattern)));

    assign o_state = r_state;

endmodule

`default_nettype wire

>>> design/mbps_chain.sv
// ----------------------------------------------------------------------------
// mbps_chain
// Row of window cells with the pattern lined up to each cell by length.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_chain (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_shift,
    input  wire logic                         i_clear,
    input  wire logic [7:0]                   i_byte,
    input  wire mbps_pkg::t_cfg               i_cfg,
    input  wire logic [mbps_pkg::LEN_BITS-1:0] i_len,
    output logic                              o_hit
);
    import mbps_pkg::*;

    t_cell_state                 prev  [MAX_PATTERN];
    t_cell_state                 state [MAX_PATTERN];
    t_cell_ref                   refs  [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]      ok;
    logic [7:0]                  pat   [LEN_LIMIT];

    for (genvar p = 0; p < LEN_LIMIT; p++) begin : g_pat
        assign pat[p] = i_cfg.pattern_words[p / 8][(p % 8) * 8 +: 8];
    end

    assign prev[0] = '{full: 1'b1, data: i_byte};

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        if (k > 0) begin : g_link
            assign prev[k] = state[k-1];
        end

        if (k < LEN_LIMIT) begin : g_ref
            logic [LEN_BITS-1:0] pidx;
            // Cell k compares the byte seen k transactions ago, which lines up
            // with pattern byte len-1-k.
            assign pidx = i_len - LEN_BITS'(1) - LEN_BITS'(k);
            assign refs[k] = '{active:  (LEN_BITS'(k) < i_len),
                               compare: i_cfg.compare_mask[pidx[IDX_BITS-1:0]],
                               pattern: pat[pidx[IDX_BITS-1:0]]};
        end else begin : g_noref
            assign refs[k] = '0;
        end

        mbps_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (i_shift),
            .i_clear (i_clear),
            .i_prev  (prev[k]),
            .i_ref   (refs[k]),
            .o_state (state[k]),
            .o_ok    (ok[k])
        );
    end

    assign o_hit = &ok;

endmodule

`default_nettype wire

>>> design/mbps_regs.sv
// ----------------------------------------------------------------------------
// mbps_regs
// APB-style configuration registers, 64-bit data, one register per 8 bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mbps_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [mbps_pkg::DATA_W-1:0]   pwdata,
    output logic      [mbps_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output mbps_pkg::t_cfg                     o_cfg
);
    import mbps_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = t_reg_idx'(paddr[PADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (idx)
                REG_PAT_LOW:      n_cfg.pattern_words[0] = pwdata;
                REG_PAT_MID_LOW:  n_cfg.pattern_words[1] = pwdata;
                REG_PAT_MID_HIGH: n_cfg.pattern_words[2] = pwdata;
                REG_PAT_HIGH:     n_cfg.pattern_words[3] = pwdata;
                REG_MASK:         n_cfg.compare_mask     = pwdata[MASK_W-1:0];
                REG_LENGTH:       n_cfg.pattern_length   = pwdata[LEN_REG_W-1:0];
                REG_BASE:         n_cfg.base_address     = pwdata;
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_words  <= '0;
            r_cfg.compare_mask   <= '1;
            r_cfg.pattern_length <= LEN_REG_W'(1);
            r_cfg.base_address   <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (idx)
            REG_PAT_LOW:      prdata = r_cfg.pattern_words[0];
            REG_PAT_MID_LOW:  prdata = r_cfg.pattern_words[1];
            REG_PAT_MID_HIGH: prdata = r_cfg.pattern_words[2];
            REG_PAT_HIGH:     prdata = r_cfg.pattern_words[3];
            REG_MASK:         prdata = DATA_W'(r_cfg.compare_mask);
            REG_LENGTH:       prdata = DATA_W'(r_cfg.pattern_length);
            REG_BASE:         prdata = r_cfg.base_address;
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> design/masked_byte_pattern_scan.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan
// Streaming search for a masked byte pattern in one memory region.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle with no gaps of its own: every
// byte is compared against all pattern positions at once by a row of 32
// window cells, so the sustained rate is one transaction per cycle. The window
// compare is done in the cycle a byte is accepted and the outcome is captured
// in stage 1 at that edge. The base address is added on the way from stage 1
// into the output register, which presents the result. Input stalls only while
// stage 1 holds a result that the stalled output register cannot take. At most
// one result is produced per region: the first match, or a not-found result
// on the region's last byte.
// Configuration is written through the APB port at byte address 8*i for
// register i.
`default_nettype none

module masked_byte_pattern_scan (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire mbps_pkg::t_in_item            i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output mbps_pkg::t_out_item                o_out_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mbps_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [mbps_pkg::DATA_W-1:0]   pwdata,
    output logic      [mbps_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);
    import mbps_pkg::*;

    t_cfg                   cfg;
    logic [LEN_BITS-1:0]    len;
    logic                   accept;
    logic                   active;
    logic                   clear;
    logic                   hit;
    logic                   result;
    logic                   out_free;
    logic                   s1_move;
    logic                   s1_free;
    logic [OFFSET_BITS-1:0] start;

    logic                   r_reported;
    logic                   n_reported;
    logic [OFFSET_BITS-1:0] r_pos;
    logic [OFFSET_BITS-1:0] n_pos;
    logic                   r_s1_valid;
    logic                   n_s1_valid;
    logic                   r_s1_found;
    logic [OFFSET_BITS-1:0] r_s1_start;
    logic                   r_out_valid;
    logic                   n_out_valid;
    t_out_item              r_out;

    mbps_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign len = eff_len(cfg.pattern_length);

    // Handshake: the stage-1 slot frees up whenever the output register can
    // take its contents.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && out_free;
    assign s1_free    = !r_s1_valid || s1_move;
    assign o_in_stall = !s1_free;

    assign accept = i_in_valid && !o_in_stall;
    assign active = accept && !r_reported;
    assign clear  = accept && i_in_data.last_byte;

    mbps_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (active),
        .i_clear (clear),
        .i_byte  (i_in_data.byte_value),
        .i_cfg   (cfg),
        .i_len   (len),
        .o_hit   (hit)
    );

    assign result = active && (hit || i_in_data.last_byte);
    assign start  = r_pos - (OFFSET_BITS'(len) - OFFSET_BITS'(1));

    always_comb begin
        n_reported = r_reported;
        n_pos      = r_pos;
        if (clear) begin
            n_reported = 1'b0;
            n_pos      = '0;
        end else if (active) begin
            n_reported = hit;
            n_pos      = r_pos + OFFSET_BITS'(1);
        end
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (result) begin
            n_s1_valid = 1'b1;
        end else if (s1_move) begin
            n_s1_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (s1_move) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reported  <= 1'b0;
            r_pos       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_reported  <= n_reported;
            r_pos       <= n_pos;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result) begin
            r_s1_found <= hit;
            r_s1_start <= start;
        end
        if (s1_move) begin
            r_out.found <= r_s1_found;
            r_out.match_address <= r_s1_found ?
                cfg.base_address + ADDR_W'(r_s1_start) : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    ap_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.found) |-> (o_out_data.match_address == '0))
        else $error("not-found result carries a nonzero address");

    ap_hold_after_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_reported && !i_in_data.last_byte) |=> r_reported)
        else $error("match flag dropped before the region ended");

    ap_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_data.last_byte) |=> (!r_reported && (r_pos == '0)))
        else $error("last byte did not rearm the scanner");

    ap_s1_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_move) |=> r_s1_valid)
        else $error("pending result lost from stage 1");

    ap_no_result_after_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_reported && !r_s1_valid) |=> !r_s1_valid)
        else $error("result produced after a match in the same region");

endmodule

`default_nettype wire
